[hw/rtl/tree_path_min_max_query_macros.svh]
`ifndef TREE_PATH_MIN_MAX_QUERY_MACROS_SVH
`define TREE_PATH_MIN_MAX_QUERY_MACROS_SVH

// Checks that a condition holds in the same cycle.
`define TPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that a condition holds in the following cycle.
`define TPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/tpq_pkg.sv]
package tpq_pkg;

	localparam int NODE_W        = 11;
	localparam int WEIGHT_W      = 20;
	localparam int DEF_MAX_NODES = 1024;
	localparam int DEF_LEVELS    = 11;

	localparam logic [WEIGHT_W-1:0] NO_PATH_MIN = 20'd1000001;
	localparam logic [WEIGHT_W-1:0] WEIGHT_CAP  = 20'd1000000;

	localparam logic [1:0] KIND_ADD   = 2'd0;
	localparam logic [1:0] KIND_BUILD = 2'd1;
	localparam logic [1:0] KIND_QUERY = 2'd2;

	typedef struct packed {
		logic [1:0]          kind;
		logic [NODE_W-1:0]   node_a;
		logic [NODE_W-1:0]   node_b;
		logic [WEIGHT_W-1:0] weight;
	} in_item_t;

	typedef struct packed {
		logic [WEIGHT_W-1:0] min_weight;
		logic [WEIGHT_W-1:0] max_weight;
		logic                error;
	} out_item_t;

	typedef enum logic [4:0] {
		S_IDLE, S_INIT, S_ROOT, S_POP, S_POPW, S_POPD, S_ERD, S_ECHK, S_EUPD,
		S_FRD1, S_FRD2, S_FWR,
		S_QRV, S_QCHK, S_QUP, S_QUPW, S_QMID, S_QBU, S_QBV, S_QBC,
		S_QFU, S_QFV, S_QFC
	} state_t;

endpackage

[hw/rtl/tpq_ram.sv]
module tpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hw/rtl/tree_path_min_max_query.sv]
// Add-edge item: stored while idle, no result. Build item: clears the node tables,
// walks the tree from node 1 over the stored edges with a stack, and then fills
// the lifting tables level by level.
// Query item: result in the cycle after acceptance on an early error, otherwise
// after the depth equalising and ancestor search steps; one item at a time, the next taken once busy falls.
// Reset clears control state and the ready flag; the result receiver cannot stall.
`include "tree_path_min_max_query_macros.svh"

module tree_path_min_max_query import tpq_pkg::*; #(
	parameter int MAX_NODES = DEF_MAX_NODES,
	parameter int LEVELS    = DEF_LEVELS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  in_item_t          item,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [NODE_W-1:0] cfg_data,
	output logic              result_valid,
	output out_item_t         result
);

	localparam int NIW    = $clog2(MAX_NODES + 1);
	localparam int LW     = $clog2(LEVELS);
	localparam int SIW    = $clog2(MAX_NODES);
	localparam int EIW    = $clog2(MAX_NODES);
	localparam int CW     = (NIW > NODE_W) ? NIW : NODE_W;
	localparam int DW     = (NIW > LEVELS) ? NIW : LEVELS;
	localparam int LIFT_W = NIW + 2 * WEIGHT_W;
	localparam int EDGE_W = 2 * NODE_W + WEIGHT_W;

	state_t state_q, state_d;

	logic [NIW-1:0] nc_q, edge_total_q, top_q, i_q, j_q, u_q, v_q, du_q, other_q, tu_q;
	logic [LW-1:0] lvl_q;
	logic [LEVELS-1:0] diff_q;
	logic [WEIGHT_W-1:0] ew_q, mn1_q, mx1_q, lo_q, hi_q;
	logic seen_u_q, ready_q, res_valid_q, finish;
	out_item_t res_q, res_d;

	logic e_we, s_we, d_we, k_we, l_we, s_wdata;
	logic [EIW-1:0] e_waddr, e_raddr;
	logic [EDGE_W-1:0] e_wdata, e_rdata;
	logic [NIW-1:0] s_waddr, s_raddr, d_waddr, d_raddr, d_wdata, d_rdata, k_wdata, k_rdata;
	logic s_rdata;
	logic [SIW-1:0] k_waddr, k_raddr;
	logic [NIW+LW-1:0] l_waddr, l_raddr;
	logic [LIFT_W-1:0] l_wdata, l_rdata;

	logic accept, q_err, ea_ok, eb_ok, usable, last_fill;
	logic [NODE_W-1:0] ea, eb;
	logic [NIW-1:0] other, l_anc, top_m1;
	logic [WEIGHT_W-1:0] l_mn, l_mx, capped;
	logic [DW-1:0] dv_ext, du_ext;

	function automatic logic [WEIGHT_W-1:0] wmin(input logic [WEIGHT_W-1:0] x,
		input logic [WEIGHT_W-1:0] y);
		return (x < y) ? x : y;
	endfunction

	function automatic logic [WEIGHT_W-1:0] wmax(input logic [WEIGHT_W-1:0] x,
		input logic [WEIGHT_W-1:0] y);
		return (x > y) ? x : y;
	endfunction

	tpq_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_NODES - 1), .AW(EIW)) u_edge_ram (
		.clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
		.raddr(e_raddr), .rdata(e_rdata));
	tpq_ram #(.WIDTH(1), .DEPTH(MAX_NODES + 1), .AW(NIW)) u_seen_ram (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.raddr(s_raddr), .rdata(s_rdata));
	tpq_ram #(.WIDTH(NIW), .DEPTH(MAX_NODES + 1), .AW(NIW)) u_depth_ram (
		.clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
		.raddr(d_raddr), .rdata(d_rdata));
	tpq_ram #(.WIDTH(NIW), .DEPTH(MAX_NODES), .AW(SIW)) u_stack_ram (
		.clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
		.raddr(k_raddr), .rdata(k_rdata));
	tpq_ram #(.WIDTH(LIFT_W), .DEPTH((MAX_NODES + 1) * (2 ** LW)), .AW(NIW + LW)) u_lift_ram (
		.clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
		.raddr(l_raddr), .rdata(l_rdata));

	assign busy         = (state_q != S_IDLE);
	assign cfg_ready    = !busy;
	assign accept       = start && !busy;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	assign q_err = !ready_q
		|| (item.node_a == '0) || (CW'(item.node_a) > CW'(nc_q))
		|| (item.node_b == '0) || (CW'(item.node_b) > CW'(nc_q));
	assign capped = (item.weight > WEIGHT_CAP) ? WEIGHT_CAP : item.weight;

	assign ea     = e_rdata[EDGE_W-1 -: NODE_W];
	assign eb     = e_rdata[WEIGHT_W +: NODE_W];
	assign ea_ok  = (ea != '0) && (CW'(ea) <= CW'(nc_q));
	assign eb_ok  = (eb != '0) && (CW'(eb) <= CW'(nc_q));
	assign other  = (CW'(ea) == CW'(u_q)) ? eb[NIW-1:0] : ea[NIW-1:0];
	assign usable = ea_ok && eb_ok && ((CW'(ea) == CW'(u_q)) || (CW'(eb) == CW'(u_q)));

	assign l_anc  = l_rdata[LIFT_W-1 -: NIW];
	assign l_mn   = l_rdata[2*WEIGHT_W-1 -: WEIGHT_W];
	assign l_mx   = l_rdata[WEIGHT_W-1:0];
	assign top_m1 = top_q - NIW'(1);
	assign dv_ext = DW'(d_rdata);
	assign du_ext = DW'(du_q);
	assign last_fill = (i_q == nc_q) && (lvl_q == LW'(LEVELS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		finish  = 1'b0;
		res_d   = '0;
		e_we = 1'b0; e_waddr = edge_total_q[EIW-1:0];
		e_wdata = {item.node_a, item.node_b, capped}; e_raddr = j_q[EIW-1:0];
		s_we = 1'b0; s_waddr = i_q; s_wdata = 1'b0; s_raddr = u_q;
		d_we = 1'b0; d_waddr = i_q; d_wdata = '0; d_raddr = u_q;
		k_we = 1'b0; k_waddr = top_q[SIW-1:0]; k_wdata = other_q; k_raddr = top_m1[SIW-1:0];
		l_we = 1'b0; l_waddr = {i_q, lvl_q}; l_wdata = '0; l_raddr = {u_q, lvl_q};
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (item.kind)
						KIND_ADD: begin
							e_we = (edge_total_q < NIW'(MAX_NODES - 1));
						end
						KIND_BUILD: begin
							state_d = S_INIT;
						end
						KIND_QUERY: begin
							if (q_err) begin
								finish      = 1'b1;
								res_d.error = 1'b1;
							end else begin
								s_raddr = item.node_a[NIW-1:0];
								d_raddr = item.node_a[NIW-1:0];
								state_d = S_QRV;
							end
						end
						default: ;
					endcase
				end
			end
			S_INIT: begin
				s_we    = 1'b1;
				d_we    = 1'b1;
				l_we    = 1'b1;
				l_waddr = {i_q, LW'(0)};
				l_wdata = {i_q, NO_PATH_MIN, WEIGHT_W'(0)};
				if (i_q == nc_q) begin
					state_d = S_ROOT;
				end
			end
			S_ROOT: begin
				s_we    = 1'b1;
				s_waddr = NIW'(1);
				s_wdata = 1'b1;
				k_we    = 1'b1;
				k_waddr = '0;
				k_wdata = NIW'(1);
				state_d = S_POP;
			end
			S_POP: begin
				state_d = (top_q == '0) ? S_FRD1 : S_POPW;
			end
			S_POPW: begin
				d_raddr = k_rdata;
				state_d = S_POPD;
			end
			S_POPD: begin
				state_d = S_ERD;
			end
			S_ERD: begin
				state_d = (j_q == edge_total_q) ? S_POP : S_ECHK;
			end
			S_ECHK: begin
				s_raddr = other;
				state_d = usable ? S_EUPD : S_ERD;
			end
			S_EUPD: begin
				if (!s_rdata) begin
					s_we    = 1'b1;
					s_waddr = other_q;
					s_wdata = 1'b1;
					d_we    = 1'b1;
					d_waddr = other_q;
					d_wdata = du_q + NIW'(1);
					l_we    = 1'b1;
					l_waddr = {other_q, LW'(0)};
					l_wdata = {u_q, ew_q, ew_q};
					k_we    = 1'b1;
				end
				state_d = S_ERD;
			end
			S_FRD1: begin
				l_raddr = {i_q, LW'(lvl_q - LW'(1))};
				state_d = S_FRD2;
			end
			S_FRD2: begin
				l_raddr = {l_anc, LW'(lvl_q - LW'(1))};
				state_d = S_FWR;
			end
			S_FWR: begin
				l_we    = 1'b1;
				l_wdata = {l_anc, wmin(mn1_q, l_mn), wmax(mx1_q, l_mx)};
				state_d = last_fill ? S_IDLE : S_FRD1;
			end
			S_QRV: begin
				s_raddr = v_q;
				d_raddr = v_q;
				state_d = S_QCHK;
			end
			S_QCHK: begin
				if (!seen_u_q || !s_rdata) begin
					finish      = 1'b1;
					res_d.error = 1'b1;
					state_d     = S_IDLE;
				end else begin
					state_d = S_QUP;
				end
			end
			S_QUP: begin
				if (diff_q[lvl_q]) begin
					state_d = S_QUPW;
				end else if (lvl_q == '0) begin
					state_d = S_QMID;
				end
			end
			S_QUPW: begin
				state_d = (lvl_q == '0) ? S_QMID : S_QUP;
			end
			S_QMID: begin
				if (u_q == v_q) begin
					finish           = 1'b1;
					res_d.min_weight = lo_q;
					res_d.max_weight = hi_q;
					state_d          = S_IDLE;
				end else begin
					state_d = S_QBU;
				end
			end
			S_QBU: begin
				state_d = S_QBV;
			end
			S_QBV: begin
				l_raddr = {v_q, lvl_q};
				state_d = S_QBC;
			end
			S_QBC: begin
				state_d = (lvl_q == '0) ? S_QFU : S_QBU;
			end
			S_QFU: begin
				l_raddr = {u_q, LW'(0)};
				state_d = S_QFV;
			end
			S_QFV: begin
				l_raddr = {v_q, LW'(0)};
				state_d = S_QFC;
			end
			S_QFC: begin
				finish           = 1'b1;
				res_d.min_weight = wmin(lo_q, wmin(mn1_q, l_mn));
				res_d.max_weight = wmax(hi_q, wmax(mx1_q, l_mx));
				state_d          = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nc_q         <= NIW'(1);
			edge_total_q <= '0;
			ready_q      <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			res_valid_q <= finish;
			if (cfg_valid && cfg_ready) begin
				if (cfg_data == '0) begin
					nc_q <= NIW'(1);
				end else if (CW'(cfg_data) > CW'(MAX_NODES)) begin
					nc_q <= NIW'(MAX_NODES);
				end else begin
					nc_q <= NIW'(cfg_data);
				end
			end
			if (e_we) begin
				edge_total_q <= edge_total_q + NIW'(1);
			end
			if ((cfg_valid && cfg_ready) || e_we) begin
				ready_q <= 1'b0;
			end else if (state_q == S_FWR && last_fill) begin
				ready_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		case (state_q)
			S_IDLE: begin
				i_q <= NIW'(1);
				u_q <= item.node_a[NIW-1:0];
				v_q <= item.node_b[NIW-1:0];
			end
			S_INIT: begin
				i_q <= i_q + NIW'(1);
			end
			S_ROOT: begin
				top_q <= NIW'(1);
			end
			S_POP: begin
				if (top_q != '0) begin
					top_q <= top_m1;
				end else begin
					i_q   <= NIW'(1);
					lvl_q <= LW'(1);
				end
			end
			S_POPW: begin
				u_q <= k_rdata;
				j_q <= '0;
			end
			S_POPD: begin
				du_q <= d_rdata;
			end
			S_ECHK: begin
				other_q <= other;
				ew_q    <= e_rdata[WEIGHT_W-1:0];
				if (!usable) begin
					j_q <= j_q + NIW'(1);
				end
			end
			S_EUPD: begin
				if (!s_rdata) begin
					top_q <= top_q + NIW'(1);
				end
				j_q <= j_q + NIW'(1);
			end
			S_FRD2: begin
				mn1_q <= l_mn;
				mx1_q <= l_mx;
			end
			S_FWR: begin
				if (i_q == nc_q) begin
					i_q   <= NIW'(1);
					lvl_q <= lvl_q + LW'(1);
				end else begin
					i_q <= i_q + NIW'(1);
				end
			end
			S_QRV: begin
				seen_u_q <= s_rdata;
				du_q     <= d_rdata;
			end
			S_QCHK: begin
				lo_q  <= NO_PATH_MIN;
				hi_q  <= '0;
				lvl_q <= LW'(LEVELS - 1);
				if (du_ext < dv_ext) begin
					u_q    <= v_q;
					v_q    <= u_q;
					diff_q <= LEVELS'(dv_ext - du_ext);
				end else begin
					diff_q <= LEVELS'(du_ext - dv_ext);
				end
			end
			S_QUP: begin
				if (!diff_q[lvl_q] && lvl_q != '0) begin
					lvl_q <= lvl_q - LW'(1);
				end
			end
			S_QUPW: begin
				lo_q <= wmin(lo_q, l_mn);
				hi_q <= wmax(hi_q, l_mx);
				u_q  <= l_anc;
				if (lvl_q != '0) begin
					lvl_q <= lvl_q - LW'(1);
				end
			end
			S_QMID: begin
				lvl_q <= LW'(LEVELS - 1);
			end
			S_QBV, S_QFV: begin
				tu_q  <= l_anc;
				mn1_q <= l_mn;
				mx1_q <= l_mx;
			end
			S_QBC: begin
				if (tu_q != l_anc) begin
					lo_q <= wmin(lo_q, wmin(mn1_q, l_mn));
					hi_q <= wmax(hi_q, wmax(mx1_q, l_mx));
					u_q  <= tu_q;
					v_q  <= l_anc;
				end
				if (lvl_q != '0) begin
					lvl_q <= lvl_q - LW'(1);
				end
			end
			default: ;
		endcase
	end

	// A clean answer needs built tables, and a failed one carries no weights.
	`TPQ_ASSERT_NOW(a_ok_needs_tables, clk, arst_n, result_valid && !result.error, ready_q,
		"result without built tables")
	`TPQ_ASSERT_NOW(a_err_zero, clk, arst_n, result_valid && result.error,
		result.min_weight == '0 && result.max_weight == '0, "error beat carries weights")
	`TPQ_ASSERT_NOW(a_stack_bound, clk, arst_n, state_q == S_EUPD, top_q < nc_q,
		"walk stack beyond node count")
	`TPQ_ASSERT_NEXT(a_build_busy, clk, arst_n, accept && item.kind == KIND_BUILD, busy,
		"build not started")

endmodule

[verif/tree_path_min_max_query_test.sv]
module tree_path_min_max_query_test;
	import tpq_pkg::*;

	localparam logic [1:0] KIND_NONE = 2'd3;
	localparam int unsigned STALL_LIMIT = 1000000;
	localparam int unsigned EDGE_SLOTS = DEF_MAX_NODES - 1;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	in_item_t item;
	logic cfg_valid;
	logic cfg_ready;
	logic [NODE_W-1:0] cfg_data;
	logic result_valid;
	out_item_t result;

	tree_path_min_max_query u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.result_valid(result_valid),
		.result(result)
	);

	// Shadow copy of the tree and the lifting tables.
	int unsigned node_limit;
	int unsigned edge_a [0:EDGE_SLOTS-1];
	int unsigned edge_b [0:EDGE_SLOTS-1];
	int unsigned edge_w [0:EDGE_SLOTS-1];
	int unsigned edges_held;
	int unsigned depth_of [0:DEF_MAX_NODES];
	int unsigned up [0:DEF_MAX_NODES][0:DEF_LEVELS-1];
	int unsigned up_min [0:DEF_MAX_NODES][0:DEF_LEVELS-1];
	int unsigned up_max [0:DEF_MAX_NODES][0:DEF_LEVELS-1];
	bit reached [0:DEF_MAX_NODES];
	int unsigned walk [0:DEF_MAX_NODES];
	bit tables_built;

	out_item_t pending_paths [$];
	int unsigned fault_count;
	int unsigned quiet_cycles;
	int unsigned beats_sent;

	typedef struct {
		bit is_cfg;
		in_item_t it;
		bit typed;
		out_item_t res;
	} plan_row_t;

	function automatic int unsigned nodes_in_use();
		if (node_limit < 1) return 1;
		if (node_limit > DEF_MAX_NODES) return DEF_MAX_NODES;
		return node_limit;
	endfunction

	function automatic void rebuild_tables();
		int unsigned nc;
		int unsigned top;
		int unsigned u;
		int unsigned other;
		int unsigned p;
		nc = nodes_in_use();
		top = 0;
		foreach (reached[i]) reached[i] = 0;
		for (int unsigned i = 1; i <= nc; i++) begin
			depth_of[i] = 0;
			up[i][0] = i;
			up_min[i][0] = NO_PATH_MIN;
			up_max[i][0] = 0;
		end
		reached[1] = 1;
		walk[top++] = 1;
		while (top > 0) begin
			u = walk[--top];
			for (int unsigned j = 0; j < edges_held; j++) begin
				if (edge_a[j] < 1 || edge_a[j] > nc || edge_b[j] < 1 || edge_b[j] > nc)
					continue;
				if (edge_a[j] == u) other = edge_b[j];
				else if (edge_b[j] == u) other = edge_a[j];
				else continue;
				if (reached[other]) continue;
				reached[other] = 1;
				depth_of[other] = depth_of[u] + 1;
				up[other][0] = u;
				up_min[other][0] = edge_w[j];
				up_max[other][0] = edge_w[j];
				if (top <= DEF_MAX_NODES) walk[top++] = other;
			end
		end
		for (int j = 1; j < DEF_LEVELS; j++) begin
			for (int unsigned i = 1; i <= nc; i++) begin
				p = up[i][j-1];
				up[i][j] = up[p][j-1];
				up_min[i][j] = up_min[i][j-1] < up_min[p][j-1] ? up_min[i][j-1] : up_min[p][j-1];
				up_max[i][j] = up_max[i][j-1] > up_max[p][j-1] ? up_max[i][j-1] : up_max[p][j-1];
			end
		end
		tables_built = 1;
	endfunction

	function automatic int unsigned lo_of(int unsigned x, int unsigned y);
		return x < y ? x : y;
	endfunction

	function automatic int unsigned hi_of(int unsigned x, int unsigned y);
		return x > y ? x : y;
	endfunction

	function automatic out_item_t path_extremes(int unsigned u, int unsigned v);
		out_item_t r;
		int unsigned nc;
		int unsigned lo;
		int unsigned hi;
		int unsigned diff;
		int unsigned t;
		nc = nodes_in_use();
		lo = NO_PATH_MIN;
		hi = 0;
		if (!tables_built || u < 1 || u > nc || v < 1 || v > nc || !reached[u] || !reached[v]) begin
			r.min_weight = '0;
			r.max_weight = '0;
			r.error = 1'b1;
			return r;
		end
		if (depth_of[u] < depth_of[v]) begin
			t = u;
			u = v;
			v = t;
		end
		diff = depth_of[u] - depth_of[v];
		for (int i = DEF_LEVELS - 1; i >= 0; i--) begin
			if ((diff >> i) & 1) begin
				lo = lo_of(lo, up_min[u][i]);
				hi = hi_of(hi, up_max[u][i]);
				u = up[u][i];
			end
		end
		if (u != v) begin
			for (int i = DEF_LEVELS - 1; i >= 0; i--) begin
				if (up[u][i] != up[v][i]) begin
					lo = lo_of(lo, lo_of(up_min[u][i], up_min[v][i]));
					hi = hi_of(hi, hi_of(up_max[u][i], up_max[v][i]));
					u = up[u][i];
					v = up[v][i];
				end
			end
			lo = lo_of(lo, lo_of(up_min[u][0], up_min[v][0]));
			hi = hi_of(hi, hi_of(up_max[u][0], up_max[v][0]));
		end
		r.min_weight = lo[WEIGHT_W-1:0];
		r.max_weight = hi[WEIGHT_W-1:0];
		r.error = 1'b0;
		return r;
	endfunction

	function automatic void absorb_item(in_item_t it, bit typed, out_item_t res);
		case (it.kind)
			KIND_ADD: begin
				if (edges_held < EDGE_SLOTS) begin
					edge_a[edges_held] = it.node_a;
					edge_b[edges_held] = it.node_b;
					edge_w[edges_held] = it.weight > WEIGHT_CAP ? WEIGHT_CAP : it.weight;
					edges_held++;
					tables_built = 0;
				end
			end
			KIND_BUILD: rebuild_tables();
			KIND_QUERY: begin
				if (typed) pending_paths = {pending_paths, res};
				else pending_paths = {pending_paths, path_extremes(it.node_a, it.node_b)};
			end
			default: ;
		endcase
	endfunction

	task automatic report(string what, int unsigned got, int unsigned want);
		$display("mismatch on %s: got %0d, expected %0d", what, got, want);
		fault_count++;
	endtask

	task automatic send_item(in_item_t it, bit typed = 0, out_item_t res = '0);
		if (!(beats_sent > 600 && beats_sent < 900) && $urandom_range(0, 99) < 10) begin
			@(negedge clk);
			start <= 1'b0;
			repeat ($urandom_range(0, 3)) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		absorb_item(it, typed, res);
		beats_sent++;
	endtask

	task automatic write_node_count(int unsigned value);
		@(negedge clk);
		start <= 1'b0;
		wait (pending_paths.size() == 0);
		@(posedge clk);
		while (busy) @(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value[NODE_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		node_limit = value[NODE_W-1:0];
		tables_built = 0;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic in_item_t make_item(logic [1:0] k, int unsigned a, int unsigned b,
		int unsigned w);
		in_item_t it;
		it.kind = k;
		it.node_a = a[NODE_W-1:0];
		it.node_b = b[NODE_W-1:0];
		it.weight = w[WEIGHT_W-1:0];
		return it;
	endfunction

	function automatic int unsigned any_weight();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 20'hFFFFF);
			1: return WEIGHT_CAP;
			2: return 1;
			default: return $urandom_range(1, 1000000);
		endcase
	endfunction

	function automatic in_item_t noisy_item(int unsigned nc);
		int unsigned pick;
		int unsigned a;
		int unsigned b;
		pick = $urandom_range(0, 99);
		a = $urandom_range(1, nc + 1);
		b = $urandom_range(1, nc + 1);
		if ($urandom_range(0, 19) == 0) a = $urandom_range(0, 2047);
		if ($urandom_range(0, 19) == 0) b = $urandom_range(0, 2047);
		if (pick < 80) return make_item(KIND_QUERY, a, b, $urandom_range(0, 20'hFFFFF));
		if (pick < 88) return make_item(KIND_ADD, a, b, any_weight());
		if (pick < 91) return make_item(KIND_BUILD, a, b, $urandom_range(0, 20'hFFFFF));
		return make_item(KIND_NONE, a, b, $urandom_range(0, 20'hFFFFF));
	endfunction

	task automatic grow_tree(int unsigned span, bit chain);
		int unsigned p;
		for (int unsigned i = 2; i <= span; i++) begin
			p = chain ? i - 1 : $urandom_range(1, i - 1);
			if ($urandom_range(0, 1)) send_item(make_item(KIND_ADD, i, p, any_weight()));
			else send_item(make_item(KIND_ADD, p, i, any_weight()));
		end
	endtask

	task automatic run_phase(int unsigned nc_value, int unsigned span, bit chain, int unsigned n);
		int unsigned nc;
		write_node_count(nc_value);
		nc = nc_value < 1 ? 1 : (nc_value > DEF_MAX_NODES ? DEF_MAX_NODES : nc_value);
		grow_tree(span, chain);
		send_item(make_item(KIND_BUILD, 0, 0, 0));
		for (int unsigned i = 0; i < n; i++) send_item(noisy_item(nc));
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && result_valid) begin
			if (pending_paths.size() == 0) begin
				$display("path result with no query outstanding");
				fault_count++;
			end else begin
				want = pending_paths.pop_front();
				if (result.min_weight !== want.min_weight)
					report("min_weight", result.min_weight, want.min_weight);
				if (result.max_weight !== want.max_weight)
					report("max_weight", result.max_weight, want.max_weight);
				if (result.error !== want.error) report("error", result.error, want.error);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		plan_row_t plan [$];
		out_item_t none_path;
		out_item_t bad_path;
		none_path = '{min_weight: NO_PATH_MIN, max_weight: '0, error: 1'b0};
		bad_path = '{min_weight: '0, max_weight: '0, error: 1'b1};
		plan = '{
			'{0, make_item(KIND_QUERY, 1, 1, 0), 1, bad_path},
			'{0, make_item(KIND_NONE, 2047, 2047, 20'hFFFFF), 0, '0},
			'{0, make_item(KIND_BUILD, 0, 0, 0), 0, '0},
			'{0, make_item(KIND_QUERY, 1, 1, 0), 1, none_path},
			'{0, make_item(KIND_QUERY, 0, 1, 0), 1, bad_path},
			'{0, make_item(KIND_QUERY, 1, 2047, 0), 1, bad_path},
			'{1, make_item(KIND_NONE, 1024, 0, 0), 0, '0},
			'{0, make_item(KIND_QUERY, 1, 1, 0), 1, bad_path},
			'{0, make_item(KIND_ADD, 1, 2, 1), 0, '0},
			'{0, make_item(KIND_ADD, 3, 2, 1000000), 0, '0},
			'{0, make_item(KIND_ADD, 2, 2, 5), 0, '0},
			'{0, make_item(KIND_ADD, 3, 1, 7), 0, '0},
			'{0, make_item(KIND_ADD, 1024, 1, 20'hFFFFF), 0, '0},
			'{0, make_item(KIND_ADD, 0, 4, 9), 0, '0},
			'{0, make_item(KIND_ADD, 4, 2047, 9), 0, '0},
			'{0, make_item(KIND_BUILD, 0, 0, 0), 0, '0},
			'{0, make_item(KIND_QUERY, 3, 1, 0), 0, '0},
			'{0, make_item(KIND_QUERY, 1024, 3, 0), 0, '0},
			'{0, make_item(KIND_QUERY, 2, 2, 0), 1, none_path},
			'{0, make_item(KIND_QUERY, 4, 1, 0), 1, bad_path},
			'{0, make_item(KIND_QUERY, 1024, 1024, 0), 1, none_path},
			'{0, make_item(KIND_QUERY, 1025, 1, 0), 1, bad_path},
			'{0, make_item(KIND_ADD, 5, 6, 3), 0, '0},
			'{0, make_item(KIND_QUERY, 1, 2, 0), 1, bad_path},
			'{0, make_item(KIND_BUILD, 0, 0, 0), 0, '0},
			'{0, make_item(KIND_QUERY, 2, 1024, 0), 0, '0}
		};

		node_limit = 1;
		edges_held = 0;
		tables_built = 0;
		fault_count = 0;
		beats_sent = 0;
		foreach (reached[i]) reached[i] = 0;
		start = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i]) begin
			if (plan[i].is_cfg) write_node_count(plan[i].it.node_a);
			else send_item(plan[i].it, plan[i].typed, plan[i].res);
		end

		run_phase(2, 2, 0, 60);
		run_phase(0, 0, 0, 30);
		run_phase(30, 30, 0, 70);
		run_phase(2047, 40, 0, 70);
		run_phase(60, 60, 1, 70);
		run_phase(17, 17, 0, 70);
		run_phase($urandom_range(3, 40), 20, 0, 70);
		run_phase(1024, 30, 0, 60);

		// Fill the edge store to the brim and past it, on a small tree.
		write_node_count(12);
		while (edges_held < EDGE_SLOTS) grow_tree(12, $urandom_range(0, 1));
		grow_tree(6, 0);
		send_item(make_item(KIND_BUILD, 0, 0, 0));
		for (int unsigned i = 0; i < 80; i++) send_item(noisy_item(12));

		@(negedge clk);
		start <= 1'b0;
		wait (pending_paths.size() == 0);
		@(posedge clk);
		while (busy) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fault_count == 0 && pending_paths.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
